// ===== src/isbn13_code_checker_core_macros.svh =====
// Assertion macros shared by the ISBN-13 checker modules.
`ifndef ISBN13_CODE_CHECKER_CORE_MACROS_SVH
`define ISBN13_CODE_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ISBN13_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ISBN13_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/isbn13_pkg.sv =====
// Package with the types shared by the ISBN-13 checker modules.
`timescale 1ns / 1ps

package isbn13_pkg;

	localparam int unsigned CH_W = 8;

	// One character beat as it moves from the input register to the parser.
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            last;
	} item_t;

endpackage

// ===== src/isbn13_code_checker_core.sv =====
// ISBN-13 checker top level: input register, parser and result register.
//
// Channel  Direction  tdata bits (low first)     Other
// s_axis   in         ch[7:0]                    tlast = last character of the text
// m_axis   out        valid_res[0], zeros [7:1]  one beat per text
//
// One character beat is taken every cycle unless a final character waits for room in the
// result register; the text's verdict is loaded into that register at the edge that consumes
// its final character from the input register and drives m_axis from there. The parser's running state is registered.
// Reset (arst_n low) clears all control state and starts a new text.
// A waiting result stalls only a further final character; ordinary characters
// keep flowing past a stalled output.
`timescale 1ns / 1ps
`include "isbn13_code_checker_core_macros.svh"

module isbn13_code_checker_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // ch[7:0]
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // valid_res[0], zero padding [7:1]
);

	// Input register: holds one character beat until the parser consumes it.
	logic              in_valid_s1;
	isbn13_pkg::item_t item_s1;

	// Result register.
	logic              out_valid_q;
	logic              out_res_q;

	logic              fire_s1;
	logic              out_free;
	logic              parse_res;

	// A final character needs room in the result register; others never wait.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire_s1       = in_valid_s1 && (!item_s1.last || out_free);
	assign s_axis_tready = !in_valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.ch   <= s_axis_tdata;
			item_s1.last <= s_axis_tlast;
		end
	end

	isbn13_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire_s1),
		.item   (item_s1),
		.result (parse_res)
	);

	// The verdict is loaded when the final character is consumed and held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && item_s1.last) begin
			out_res_q <= parse_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_res_q};

	`ISBN13_ASSERT_NEXT(a_last_gives_result, fire_s1 && item_s1.last, out_valid_q,
		"final character consumed without a result beat")
	`ISBN13_ASSERT_SAME(a_no_overwrite,
		out_valid_q && !m_axis_tready && in_valid_s1 && item_s1.last, !fire_s1,
		"pending result would be overwritten")
	`ISBN13_ASSERT_SAME(a_result_source, $rose(out_valid_q), $past(fire_s1 && item_s1.last),
		"result beat appeared without a final character")

endmodule

// ===== src/isbn13_parse.sv =====
// Character parser: running state of one ISBN-13 text and the final verdict.
`timescale 1ns / 1ps
`include "isbn13_code_checker_core_macros.svh"

module isbn13_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  isbn13_pkg::item_t  item,
	output logic               result
);

	localparam logic [1:0] PART_PREFIX    = 2'd0;
	localparam logic [1:0] PART_GROUP     = 2'd1;
	localparam logic [1:0] PART_PUBLISHER = 2'd2;
	localparam logic [1:0] PART_REST      = 2'd3;

	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_EIGHT  = 8'h38;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [4:0] POS_MAX = 5'd31;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		begin
			case (idx)
				3'd0:    c = 8'h49; // I
				3'd1:    c = 8'h53; // S
				3'd2:    c = 8'h42; // B
				3'd3:    c = 8'h4E; // N
				default: c = 8'h20; // space
			endcase
			return c;
		end
	endfunction

	function automatic logic [3:0] mod10(input logic [5:0] v);
		logic [5:0] r;
		begin
			if (v >= 6'd30) begin
				r = v - 6'd30;
			end else if (v >= 6'd20) begin
				r = v - 6'd20;
			end else if (v >= 6'd10) begin
				r = v - 6'd10;
			end else begin
				r = v;
			end
			return r[3:0];
		end
	endfunction

	function automatic logic group_rule(input logic [2:0] len, input logic [3:0] a,
		input logic [3:0] b, input logic [3:0] c);
		logic r;
		begin
			case (len)
				3'd1:    r = (a <= 4'd5) || (a == 4'd7);
				3'd2:    r = (a >= 4'd8) && (b < 4'd5);
				3'd3:    r = ((a == 4'd6) && (b < 4'd5)) ||
						((a == 4'd9) && (b >= 4'd5) && (b < 4'd9));
				3'd4:    r = (a == 4'd9) && (b == 4'd9) && (c <= 4'd8);
				3'd5:    r = (a == 4'd9) && (b == 4'd9) && (c == 4'd9);
				default: r = 1'b0;
			endcase
			return r;
		end
	endfunction

	function automatic logic publisher_rule(input logic [3:0] len, input logic [3:0] a,
		input logic [3:0] b);
		logic r;
		begin
			case (len)
				4'd1:    r = 1'b1;
				4'd2:    r = a < 4'd2;
				4'd3:    r = (a >= 4'd2) && (a < 4'd7);
				4'd4:    r = (a == 4'd7) || ((a == 4'd8) && (b < 4'd5));
				4'd5:    r = (a == 4'd8) && (b >= 4'd5);
				4'd6:    r = (a == 4'd9) && (b < 4'd5);
				4'd7:    r = (a == 4'd9) && (b >= 4'd5);
				default: r = 1'b0;
			endcase
			return r;
		end
	endfunction

	logic [4:0] pos_q;
	logic       ok_q;
	logic [3:0] sum_q;
	logic       w3_q;
	logic       hy_q;
	logic [1:0] part_q;
	logic [2:0] glen_q;
	logic [3:0] plen_q;
	logic [3:0] grp_q [3];
	logic [3:0] pub_q [2];

	logic [4:0] pos_n;
	logic       ok_n;
	logic [3:0] sum_n;
	logic       w3_n;
	logic       hy_n;
	logic [1:0] part_n;
	logic [2:0] glen_n;
	logic [3:0] plen_n;
	logic       grp_we;
	logic       pub_we;
	logic       valid_n;

	logic       hy;
	logic       dig;
	logic [3:0] d;
	logic [5:0] weighted;
	logic [4:0] check_total;
	logic       in_fields;

	always_comb begin
		hy          = item.ch == CH_HYPHEN;
		dig         = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
		d           = dig ? item.ch[3:0] : 4'd0;
		weighted    = w3_q ? ({1'b0, d, 1'b0} + {2'b00, d}) : {2'b00, d};
		check_total = {1'b0, sum_q} + {1'b0, d};
		in_fields   = (pos_q >= 5'd9) && (pos_q <= 5'd21);

		ok_n    = ok_q;
		sum_n   = sum_q;
		w3_n    = w3_q;
		hy_n    = hy_q;
		part_n  = part_q;
		glen_n  = glen_q;
		plen_n  = plen_q;
		grp_we  = 1'b0;
		pub_we  = 1'b0;
		valid_n = 1'b0;

		if (pos_q <= 5'd4) begin
			ok_n = ok_n && (item.ch == prefix_char(pos_q[2:0]));
		end else if (pos_q <= 5'd19) begin
			if (pos_q == 5'd5) begin
				ok_n = ok_n && (item.ch == CH_NINE);
			end else if (pos_q == 5'd6) begin
				ok_n = ok_n && (item.ch == CH_SEVEN);
			end else if (pos_q == 5'd7) begin
				ok_n = ok_n && ((item.ch == CH_EIGHT) || (item.ch == CH_NINE));
			end else if (pos_q == 5'd8) begin
				ok_n = ok_n && hy;
			end
			if (hy) begin
				if (hy_q) begin
					ok_n = 1'b0;
				end
				hy_n = 1'b1;
			end else begin
				if (dig) begin
					sum_n = mod10(weighted + {2'b00, sum_q});
					w3_n  = !w3_q;
				end else begin
					ok_n = 1'b0;
				end
				hy_n = 1'b0;
			end
		end else if (pos_q == 5'd20) begin
			ok_n = ok_n && hy && !hy_q;
			hy_n = hy;
		end else if (pos_q == 5'd21) begin
			// Check digit plus the running sum must be a multiple of ten.
			valid_n = ok_n && dig && (part_q == PART_REST) &&
				((check_total == 5'd0) || (check_total == 5'd10));
		end else begin
			ok_n = 1'b0;
		end

		if (in_fields) begin
			if (part_q == PART_GROUP) begin
				if (hy) begin
					ok_n   = ok_n && group_rule(glen_q, grp_q[0], grp_q[1], grp_q[2]);
					part_n = PART_PUBLISHER;
				end else begin
					grp_we = glen_q < 3'd3;
					if (glen_q != 3'd7) begin
						glen_n = glen_q + 3'd1;
					end
				end
			end else if (part_q == PART_PUBLISHER) begin
				if (hy) begin
					ok_n   = ok_n && publisher_rule(plen_q, pub_q[0], pub_q[1]);
					part_n = PART_REST;
				end else begin
					pub_we = plen_q < 4'd2;
					if (plen_q != 4'd15) begin
						plen_n = plen_q + 4'd1;
					end
				end
			end
		end
		if (pos_q == 5'd8) begin
			part_n = PART_GROUP;
		end

		pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + 5'd1;
	end

	assign result = valid_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ok_q   <= 1'b1;
			sum_q  <= '0;
			w3_q   <= 1'b0;
			hy_q   <= 1'b0;
			part_q <= PART_PREFIX;
			glen_q <= '0;
			plen_q <= '0;
		end else if (step) begin
			if (item.last) begin
				pos_q  <= '0;
				ok_q   <= 1'b1;
				sum_q  <= '0;
				w3_q   <= 1'b0;
				hy_q   <= 1'b0;
				part_q <= PART_PREFIX;
				glen_q <= '0;
				plen_q <= '0;
			end else begin
				pos_q  <= pos_n;
				ok_q   <= ok_n;
				sum_q  <= sum_n;
				w3_q   <= w3_n;
				hy_q   <= hy_n;
				part_q <= part_n;
				glen_q <= glen_n;
				plen_q <= plen_n;
			end
		end
	end

	// Digit stores: only entries already written are ever read by the rules.
	always_ff @(posedge clk) begin
		if (step && grp_we) begin
			grp_q[glen_q[1:0]] <= d;
		end
		if (step && pub_we) begin
			pub_q[plen_q[0]] <= d;
		end
	end

	`ISBN13_ASSERT_NEXT(a_last_restarts, step && item.last,
		(pos_q == 5'd0) && ok_q && (part_q == PART_PREFIX),
		"parser state not restarted after the final character")
	`ISBN13_ASSERT_SAME(a_part_after_prefix, part_q != PART_PREFIX, pos_q >= 5'd9,
		"field tracking started before the prefix was complete")
	`ISBN13_ASSERT_SAME(a_group_len_in_field, glen_q != 3'd0, part_q != PART_PREFIX,
		"group digits counted outside the fields")

endmodule

// ===== verif/isbn13_code_checker_core_test.sv =====
// Self-checking testbench for the ISBN-13 checker core: streamed texts against predicted verdicts.
`timescale 1ns / 1ps

module isbn13_code_checker_core_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_CHARS = 1350;
	localparam logic [isbn13_pkg::CH_W-1:0] ASCII_HYPHEN = 8'h2D;
	localparam logic [isbn13_pkg::CH_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [isbn13_pkg::CH_W-1:0] ASCII_NINE = 8'h39;
	localparam logic [39:0] PREFIX_TEXT = "ISBN ";

	typedef enum logic [1:0] {PART_PREFIX, PART_GROUP, PART_PUBLISHER, PART_REST} field_part_t;
	typedef enum int {MUT_ANY_BYTE, MUT_FIELD_CHAR, MUT_CHECK_CHAR, MUT_DROP, MUT_INSERT,
		MUT_MERGE} mutation_t;

	// Follows the text as the core parses it and keeps the verdicts still to come.
	class verdict_scoreboard;
		bit verdicts_due[$];
		int mismatches;
		logic [4:0] position;
		logic still_ok;
		logic [3:0] digit_sum;
		logic triple;
		logic after_hyphen;
		field_part_t part;
		logic [3:0] group_dig[3];
		logic [2:0] group_len;
		logic [3:0] pub_dig[2];
		logic [3:0] pub_len;

		function new();
			mismatches = 0;
			clear_text();
		endfunction

		function void clear_text();
			position = 0;
			still_ok = 1'b1;
			digit_sum = 0;
			triple = 1'b0;
			after_hyphen = 1'b0;
			part = PART_PREFIX;
			foreach (group_dig[i]) group_dig[i] = 0;
			foreach (pub_dig[i]) pub_dig[i] = 0;
			group_len = 0;
			pub_len = 0;
		endfunction

		function bit group_fits();
			case (group_len)
			3'd1: return group_dig[0] <= 5 || group_dig[0] == 7;
			3'd2: return group_dig[0] >= 8 && group_dig[1] < 5;
			3'd3: return (group_dig[0] == 6 && group_dig[1] < 5) ||
				(group_dig[0] == 9 && group_dig[1] >= 5 && group_dig[1] < 9);
			3'd4: return group_dig[0] == 9 && group_dig[1] == 9 && group_dig[2] <= 8;
			3'd5: return group_dig[0] == 9 && group_dig[1] == 9 && group_dig[2] == 9;
			default: return 1'b0;
			endcase
		endfunction

		function bit publisher_fits();
			case (pub_len)
			4'd1: return 1'b1;
			4'd2: return pub_dig[0] < 2;
			4'd3: return pub_dig[0] >= 2 && pub_dig[0] < 7;
			4'd4: return pub_dig[0] == 7 || (pub_dig[0] == 8 && pub_dig[1] < 5);
			4'd5: return pub_dig[0] == 8 && pub_dig[1] >= 5;
			4'd6: return pub_dig[0] == 9 && pub_dig[1] < 5;
			4'd7: return pub_dig[0] == 9 && pub_dig[1] >= 5;
			default: return 1'b0;
			endcase
		endfunction

		// Advances the parse by one accepted character; a closing character queues a verdict.
		function void note_char(logic [isbn13_pkg::CH_W-1:0] ch, logic last);
			logic [4:0] p;
			logic hy, dig, ok, good;
			logic [3:0] d;
			int acc;
			p = position;
			hy = ch == ASCII_HYPHEN;
			dig = ch >= ASCII_ZERO && ch <= ASCII_NINE;
			d = dig ? ch[3:0] : 4'd0;
			ok = still_ok;
			good = 1'b0;
			if (p <= 4) begin
				ok = ok && ch == PREFIX_TEXT[39 - 8 * p -: 8];
			end else if (p <= 19) begin
				if (p == 5) ok = ok && ch == "9";
				else if (p == 6) ok = ok && ch == "7";
				else if (p == 7) ok = ok && (ch == "8" || ch == "9");
				else if (p == 8) ok = ok && hy;
				if (hy) begin
					if (after_hyphen) ok = 1'b0;
					after_hyphen = 1'b1;
				end else begin
					if (dig) begin
						acc = digit_sum + d * (triple ? 3 : 1);
						digit_sum = 4'(acc % 10);
						triple = !triple;
					end else begin
						ok = 1'b0;
					end
					after_hyphen = 1'b0;
				end
			end else if (p == 20) begin
				ok = ok && hy && !after_hyphen;
				after_hyphen = hy;
			end else if (p == 21) begin
				good = ok && dig && part == PART_REST && d == (10 - digit_sum) % 10;
			end else begin
				ok = 1'b0;
			end
			// Group and publisher lengths are counted up to their closing hyphens.
			if (p >= 9 && p <= 21) begin
				if (part == PART_GROUP) begin
					if (hy) begin
						ok = ok && group_fits();
						part = PART_PUBLISHER;
					end else begin
						if (group_len < 3) group_dig[group_len] = d;
						if (group_len < 7) group_len++;
					end
				end else if (part == PART_PUBLISHER) begin
					if (hy) begin
						ok = ok && publisher_fits();
						part = PART_REST;
					end else begin
						if (pub_len < 2) pub_dig[pub_len] = d;
						if (pub_len < 15) pub_len++;
					end
				end
			end
			if (p == 8) part = PART_GROUP;
			still_ok = ok;
			if (position < 31) position++;
			if (last) begin
				verdicts_due.push_back(p == 21 && good && ok);
				clear_text();
			end
		endfunction

		task report(string msg);
			$display("%0t: verdict error: %s", $time, msg);
			mismatches++;
		endtask

		task check_verdict(logic seen);
			bit want;
			if (verdicts_due.size() == 0) begin
				report($sformatf("verdict %0b arrived with no text closed", seen));
			end else begin
				want = verdicts_due.pop_front();
				if (seen !== want) report($sformatf("valid_res %0b, predicted %0b", seen, want));
			end
		endtask

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [7:0] m_axis_tdata;

	verdict_scoreboard sb;
	logic [isbn13_pkg::CH_W-1:0] text_q[$];
	int burst_left = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int sent_chars = 0;

	isbn13_code_checker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [isbn13_pkg::CH_W-1:0] digit_char(int v);
		return ASCII_ZERO + 8'(v);
	endfunction

	// Sends one beat; between bursts of random length the sender takes a random gap.
	task automatic send_beat(logic [isbn13_pkg::CH_W-1:0] ch, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_char(ch, last);
		burst_left--;
	endtask

	task automatic send_text();
		foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
		sent_chars += text_q.size();
	endtask

	// Holds the sender back until every closed text has had its verdict.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		burst_left = 0;
	endtask

	task automatic load_text(string s);
		text_q = {};
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	// Rewrites the check character so that the weighted digit sum comes out right.
	task automatic fix_check();
		int acc;
		bit triple;
		acc = 0;
		triple = 1'b0;
		for (int i = 5; i <= 19; i++) begin
			if (text_q[i] >= ASCII_ZERO && text_q[i] <= ASCII_NINE) begin
				acc += (text_q[i] - ASCII_ZERO) * (triple ? 3 : 1);
				triple = !triple;
			end
		end
		text_q[21] = digit_char((10 - acc % 10) % 10);
	endtask

	// Builds a 22-character text whose fields mostly keep to the range rules.
	task automatic build_valid_text();
		int g, p, t;
		int gd[5];
		int pd[7];
		load_text("ISBN 97");
		text_q.push_back($urandom_range(1) ? "9" : "8");
		text_q.push_back(ASCII_HYPHEN);
		g = $urandom_range(1, 5);
		p = $urandom_range(1, (8 - g) < 7 ? 8 - g : 7);
		t = 9 - g - p;
		foreach (gd[i]) gd[i] = $urandom_range(9);
		foreach (pd[i]) pd[i] = $urandom_range(9);
		if ($urandom_range(3) != 0) begin
			case (g)
			1: begin
				gd[0] = $urandom_range(6);
				if (gd[0] == 6) gd[0] = 7;
			end
			2: begin
				gd[0] = $urandom_range(8, 9);
				gd[1] = $urandom_range(4);
			end
			3: begin
				if ($urandom_range(1)) begin
					gd[0] = 6;
					gd[1] = $urandom_range(4);
				end else begin
					gd[0] = 9;
					gd[1] = $urandom_range(5, 8);
				end
			end
			4: begin
				gd[0] = 9;
				gd[1] = 9;
				gd[2] = $urandom_range(8);
			end
			default: begin
				gd[0] = 9;
				gd[1] = 9;
				gd[2] = 9;
			end
			endcase
			case (p)
			2: pd[0] = $urandom_range(1);
			3: pd[0] = $urandom_range(2, 6);
			4: begin
				if ($urandom_range(1)) begin
					pd[0] = 7;
				end else begin
					pd[0] = 8;
					pd[1] = $urandom_range(4);
				end
			end
			5: begin
				pd[0] = 8;
				pd[1] = $urandom_range(5, 9);
			end
			6: begin
				pd[0] = 9;
				pd[1] = $urandom_range(4);
			end
			7: begin
				pd[0] = 9;
				pd[1] = $urandom_range(5, 9);
			end
			default: ;
			endcase
		end
		for (int i = 0; i < g; i++) text_q.push_back(digit_char(gd[i]));
		text_q.push_back(ASCII_HYPHEN);
		for (int i = 0; i < p; i++) text_q.push_back(digit_char(pd[i]));
		text_q.push_back(ASCII_HYPHEN);
		for (int i = 0; i < t; i++) text_q.push_back(digit_char($urandom_range(9)));
		text_q.push_back(ASCII_HYPHEN);
		text_q.push_back(ASCII_ZERO);
		fix_check();
	endtask

	// Breaks a well-formed text in one place.
	task automatic mutate_text();
		mutation_t kind;
		int i;
		int hyphens[$];
		kind = mutation_t'($urandom_range(5));
		case (kind)
		MUT_ANY_BYTE: text_q[$urandom_range(21)] = 8'($urandom_range(255));
		MUT_FIELD_CHAR: begin
			i = $urandom_range(5, 21);
			text_q[i] = ($urandom_range(3) == 0) ? ASCII_HYPHEN : digit_char($urandom_range(9));
			if ($urandom_range(1)) fix_check();
		end
		MUT_CHECK_CHAR: text_q[21] = $urandom_range(1) ? digit_char($urandom_range(9)) :
			8'($urandom_range(255));
		MUT_DROP: text_q.delete($urandom_range(21));
		MUT_INSERT: text_q.insert($urandom_range(21), 8'($urandom_range(255)));
		default: begin
			// Joining two fields lengthens the group or the publisher.
			for (int j = 9; j <= 19; j++) if (text_q[j] == ASCII_HYPHEN) hyphens.push_back(j);
			if (hyphens.size() > 0)
				text_q[hyphens[$urandom_range(hyphens.size() - 1)]] = digit_char($urandom_range(9));
			if ($urandom_range(1)) fix_check();
		end
		endcase
	endtask

	// Texts of random length, either raw bytes or digits and hyphens after a good prefix.
	task automatic build_noise(bit with_prefix);
		int n;
		if (with_prefix) begin
			load_text("ISBN 978-");
			n = $urandom_range(1, 31);
		end else begin
			text_q = {};
			n = $urandom_range(1, 40);
		end
		repeat (n) begin
			if (with_prefix)
				text_q.push_back(($urandom_range(4) == 0) ? ASCII_HYPHEN : digit_char($urandom_range(9)));
			else
				text_q.push_back(8'($urandom_range(255)));
		end
	endtask

	function automatic logic ready_pattern();
		case ((cycle_count / 250) % 4)
		0: return 1'b1;
		1: return 1'($urandom_range(1));
		2: return $urandom_range(3) == 0;
		default: begin
			if (stall_left > 0) begin
				stall_left--;
				return 1'b0;
			end
			if ($urandom_range(7) == 0) begin
				stall_left = $urandom_range(5, 25);
				return 1'b0;
			end
			return 1'b1;
		end
		endcase
	endfunction

	// Verdict monitor, receiver stall pattern and run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata[0]);
			m_axis_tready <= ready_pattern();
		end
	end

	initial begin
		int texts;
		int pick;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A known good code, then one-character texts at both ends of the byte range.
		load_text("ISBN 978-0-306-40615-7");
		send_text();
		text_q = {8'h00};
		send_text();
		text_q = {8'hFF};
		send_text();
		settle();

		texts = 0;
		while (sent_chars < RANDOM_CHARS + 24) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				build_valid_text();
			end else if (pick < 85) begin
				build_valid_text();
				mutate_text();
			end else begin
				build_noise(pick >= 92);
			end
			send_text();
			texts++;
			if (texts == 25) settle();
		end

		settle();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
